// ===== rtl/pfpq_pkg.sv =====
`default_nettype none

package pfpq_pkg;

    localparam int unsigned POWER_WIDTH = 22;
    localparam int unsigned MAG_W       = POWER_WIDTH;
    localparam int unsigned SUM_W       = 2 * POWER_WIDTH;
    localparam int unsigned ROOT_W      = POWER_WIDTH;
    // The partial remainder of the root never exceeds twice the partial root.
    localparam int unsigned REM_W       = POWER_WIDTH + 3;
    localparam int unsigned PF_W        = 10;
    localparam int unsigned NUM_W       = POWER_WIDTH + PF_W;
    localparam int unsigned PF_SCALE    = 1000;

    typedef logic [MAG_W-1:0] t_mag;

    typedef struct packed {
        logic [NUM_W-1:0] num;
        logic [SUM_W-1:0] sum;
    } t_front_data;

    typedef struct packed {
        logic [NUM_W-1:0]  num;
        logic [ROOT_W-1:0] root;
    } t_root_data;

    // Magnitude of a two's complement reading; the most negative value maps
    // to 2^(POWER_WIDTH-1), which still fits the unsigned width.
    function automatic t_mag f_magnitude(input logic [POWER_WIDTH-1:0] x);
        t_mag m;
        m = x[POWER_WIDTH-1] ? t_mag'(~x + 1'b1) : t_mag'(x);
        return m;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/pfpq_front.sv =====
`default_nettype none

module pfpq_front (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_valid,
    input  wire logic [pfpq_pkg::POWER_WIDTH-1:0] i_active_power,
    input  wire logic [pfpq_pkg::POWER_WIDTH-1:0] i_reactive_power,
    output logic                                  o_ready,
    output logic                                  o_valid,
    output pfpq_pkg::t_front_data                 o_data,
    input  wire logic                             i_ready
);

    logic                        r_v0, r_v1, r_v2;
    pfpq_pkg::t_mag              r_p0, r_q0;
    logic [pfpq_pkg::SUM_W-1:0]  r_pp, r_qq, r_sum;
    logic [pfpq_pkg::NUM_W-1:0]  r_num1, r_num2;
    logic [pfpq_pkg::SUM_W-1:0]  n_pp, n_qq, n_sum;
    logic [pfpq_pkg::NUM_W-1:0]  n_num;
    logic                        rdy0, rdy1, rdy2;

    // A stage loads when it is empty or its contents move on this cycle.
    assign rdy2    = !r_v2 || i_ready;
    assign rdy1    = !r_v1 || rdy2;
    assign rdy0    = !r_v0 || rdy1;
    assign o_ready = rdy0;

    assign n_pp  = pfpq_pkg::SUM_W'(r_p0) * pfpq_pkg::SUM_W'(r_p0);
    assign n_qq  = pfpq_pkg::SUM_W'(r_q0) * pfpq_pkg::SUM_W'(r_q0);
    assign n_num = pfpq_pkg::NUM_W'(r_p0) * pfpq_pkg::NUM_W'(pfpq_pkg::PF_SCALE);
    assign n_sum = r_pp + r_qq;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            if (rdy0) begin
                r_v0 <= i_valid;
            end
            if (rdy1) begin
                r_v1 <= r_v0;
            end
            if (rdy2) begin
                r_v2 <= r_v1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy0) begin
            r_p0 <= pfpq_pkg::f_magnitude(i_active_power);
            r_q0 <= pfpq_pkg::f_magnitude(i_reactive_power);
        end
        if (rdy1) begin
            r_pp   <= n_pp;
            r_qq   <= n_qq;
            r_num1 <= n_num;
        end
        if (rdy2) begin
            r_sum  <= n_sum;
            r_num2 <= r_num1;
        end
    end

    assign o_valid    = r_v2;
    assign o_data.num = r_num2;
    assign o_data.sum = r_sum;

endmodule

`default_nettype wire

// ===== rtl/pfpq_sqrt.sv =====
`default_nettype none

module pfpq_sqrt (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_valid,
    input  pfpq_pkg::t_front_data i_data,
    output logic                  o_ready,
    output logic                  o_valid,
    output pfpq_pkg::t_root_data  o_data,
    input  wire logic             i_ready
);

    // Index k of a w_ array is what enters stage k; index k+1 is what leaves it.
    logic                        w_valid [0:pfpq_pkg::ROOT_W];
    logic                        w_ready [0:pfpq_pkg::ROOT_W];
    logic [pfpq_pkg::SUM_W-1:0]  w_rad   [0:pfpq_pkg::ROOT_W];
    logic [pfpq_pkg::REM_W-1:0]  w_rem   [0:pfpq_pkg::ROOT_W];
    logic [pfpq_pkg::ROOT_W-1:0] w_root  [0:pfpq_pkg::ROOT_W];
    logic [pfpq_pkg::NUM_W-1:0]  w_num   [0:pfpq_pkg::ROOT_W];

    logic                        r_valid [0:pfpq_pkg::ROOT_W-1];
    logic [pfpq_pkg::SUM_W-1:0]  r_rad   [0:pfpq_pkg::ROOT_W-1];
    logic [pfpq_pkg::REM_W-1:0]  r_rem   [0:pfpq_pkg::ROOT_W-1];
    logic [pfpq_pkg::ROOT_W-1:0] r_root  [0:pfpq_pkg::ROOT_W-1];
    logic [pfpq_pkg::NUM_W-1:0]  r_num   [0:pfpq_pkg::ROOT_W-1];

    assign w_valid[0]              = i_valid;
    assign w_rad[0]                = i_data.sum;
    assign w_rem[0]                = '0;
    assign w_root[0]               = '0;
    assign w_num[0]                = i_data.num;
    assign w_ready[pfpq_pkg::ROOT_W] = i_ready;

    // One root bit per stage: bring down two radicand bits and try 4*root+1.
    for (genvar k = 0; k < pfpq_pkg::ROOT_W; k++) begin : g_stage
        logic [pfpq_pkg::REM_W-1:0] n_rem_sh;
        logic [pfpq_pkg::REM_W-1:0] n_trial;
        logic                       n_ge;

        assign n_rem_sh = {w_rem[k][pfpq_pkg::REM_W-3:0], w_rad[k][pfpq_pkg::SUM_W-1 -: 2]};
        assign n_trial  = pfpq_pkg::REM_W'({w_root[k], 2'b01});
        assign n_ge     = n_rem_sh >= n_trial;
        assign w_ready[k] = !r_valid[k] || w_ready[k+1];

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_valid[k] <= 1'b0;
            end else if (w_ready[k]) begin
                r_valid[k] <= w_valid[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_ready[k]) begin
                r_rem[k]  <= n_ge ? n_rem_sh - n_trial : n_rem_sh;
                r_root[k] <= {w_root[k][pfpq_pkg::ROOT_W-2:0], n_ge};
                r_rad[k]  <= {w_rad[k][pfpq_pkg::SUM_W-3:0], 2'b00};
                r_num[k]  <= w_num[k];
            end
        end

        assign w_valid[k+1] = r_valid[k];
        assign w_rad[k+1]   = r_rad[k];
        assign w_rem[k+1]   = r_rem[k];
        assign w_root[k+1]  = r_root[k];
        assign w_num[k+1]   = r_num[k];
    end

    assign o_ready     = w_ready[0];
    assign o_valid     = w_valid[pfpq_pkg::ROOT_W];
    assign o_data.root = w_root[pfpq_pkg::ROOT_W];
    assign o_data.num  = w_num[pfpq_pkg::ROOT_W];

endmodule

`default_nettype wire

// ===== rtl/pfpq_div.sv =====
`default_nettype none

module pfpq_div (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_valid,
    input  pfpq_pkg::t_root_data           i_data,
    output logic                           o_ready,
    output logic                           o_valid,
    output logic [pfpq_pkg::PF_W-1:0]      o_power_factor,
    input  wire logic                      i_ready
);

    logic                        w_valid [0:pfpq_pkg::PF_W];
    logic                        w_ready [0:pfpq_pkg::PF_W];
    logic [pfpq_pkg::NUM_W-1:0]  w_rem   [0:pfpq_pkg::PF_W];
    logic [pfpq_pkg::ROOT_W-1:0] w_div   [0:pfpq_pkg::PF_W];
    logic [pfpq_pkg::PF_W-1:0]   w_quot  [0:pfpq_pkg::PF_W];

    logic                        r_valid [0:pfpq_pkg::PF_W-1];
    logic [pfpq_pkg::NUM_W-1:0]  r_rem   [0:pfpq_pkg::PF_W-1];
    logic [pfpq_pkg::ROOT_W-1:0] r_div   [0:pfpq_pkg::PF_W-1];
    logic [pfpq_pkg::PF_W-1:0]   r_quot  [0:pfpq_pkg::PF_W-1];

    logic                        r_out_valid;
    logic [pfpq_pkg::PF_W-1:0]   r_pf;
    logic [pfpq_pkg::PF_W-1:0]   n_pf;

    assign w_valid[0] = i_valid;
    assign w_rem[0]   = i_data.num;
    assign w_div[0]   = i_data.root;
    assign w_quot[0]  = '0;

    // Restoring division, most significant quotient bit first. Since the
    // root is never below |P|, the quotient fits in PF_W bits.
    for (genvar k = 0; k < pfpq_pkg::PF_W; k++) begin : g_stage
        logic [pfpq_pkg::NUM_W-1:0] n_dsh;
        logic                       n_ge;

        assign n_dsh = pfpq_pkg::NUM_W'(w_div[k]) << (pfpq_pkg::PF_W - 1 - k);
        assign n_ge  = w_rem[k] >= n_dsh;
        assign w_ready[k] = !r_valid[k] || w_ready[k+1];

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_valid[k] <= 1'b0;
            end else if (w_ready[k]) begin
                r_valid[k] <= w_valid[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_ready[k]) begin
                r_rem[k]  <= n_ge ? w_rem[k] - n_dsh : w_rem[k];
                r_div[k]  <= w_div[k];
                r_quot[k] <= w_quot[k] |
                             (pfpq_pkg::PF_W'(n_ge) << (pfpq_pkg::PF_W - 1 - k));
            end
        end

        assign w_valid[k+1] = r_valid[k];
        assign w_rem[k+1]   = r_rem[k];
        assign w_div[k+1]   = r_div[k];
        assign w_quot[k+1]  = r_quot[k];
    end

    // A zero root means both powers were zero, which reads as unity.
    assign n_pf = (w_div[pfpq_pkg::PF_W] == '0) ? pfpq_pkg::PF_W'(pfpq_pkg::PF_SCALE)
                                                 : w_quot[pfpq_pkg::PF_W];
    assign w_ready[pfpq_pkg::PF_W] = !r_out_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_ready[pfpq_pkg::PF_W]) begin
            r_out_valid <= w_valid[pfpq_pkg::PF_W];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ready[pfpq_pkg::PF_W]) begin
            r_pf <= n_pf;
        end
    end

    assign o_ready        = w_ready[0];
    assign o_valid        = r_out_valid;
    assign o_power_factor = r_pf;

    a_pf_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> r_pf <= pfpq_pkg::PF_W'(pfpq_pkg::PF_SCALE))
        else $error("power factor above full scale");

    a_quot_fits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_valid[0] && w_div[0] != '0) |->
            w_rem[0] < (pfpq_pkg::NUM_W'(w_div[0]) << pfpq_pkg::PF_W))
        else $error("dividend too large for the quotient width");

    a_rem_final: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_valid[pfpq_pkg::PF_W] && w_div[pfpq_pkg::PF_W] != '0) |->
            w_rem[pfpq_pkg::PF_W] < pfpq_pkg::NUM_W'(w_div[pfpq_pkg::PF_W]))
        else $error("final remainder not below divisor");

endmodule

`default_nettype wire

// ===== rtl/power_factor_from_pq_top.sv =====
// An accepted transaction passes through the front stages (magnitude, squaring and
// sum), the root stages (one bit per stage), the division stages (one quotient bit
// per stage) and the output register before its result reaches the output.
// Throughput: one transaction per cycle while i_stall is low; every stage
// advances whenever it is empty or its successor advances. Reset (i_rst_n low,
// synchronous) drops all transactions in flight and holds no other state.
`default_nettype none

module power_factor_from_pq_top (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_valid,
    output logic                                  o_stall,
    input  wire logic [pfpq_pkg::POWER_WIDTH-1:0] i_active_power,
    input  wire logic [pfpq_pkg::POWER_WIDTH-1:0] i_reactive_power,
    output logic                                  o_valid,
    input  wire logic                             i_stall,
    output logic [pfpq_pkg::PF_W-1:0]             o_power_factor
);

    logic                  front_ready, front_valid;
    pfpq_pkg::t_front_data front_data;
    logic                  sqrt_ready, sqrt_valid;
    pfpq_pkg::t_root_data  sqrt_data;
    logic                  div_ready;

    pfpq_front u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .i_active_power   (i_active_power),
        .i_reactive_power (i_reactive_power),
        .o_ready          (front_ready),
        .o_valid          (front_valid),
        .o_data           (front_data),
        .i_ready          (sqrt_ready)
    );

    pfpq_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (front_valid),
        .i_data  (front_data),
        .o_ready (sqrt_ready),
        .o_valid (sqrt_valid),
        .o_data  (sqrt_data),
        .i_ready (div_ready)
    );

    pfpq_div u_div (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (sqrt_valid),
        .i_data         (sqrt_data),
        .o_ready        (div_ready),
        .o_valid        (o_valid),
        .o_power_factor (o_power_factor),
        .i_ready        (!i_stall)
    );

    assign o_stall = !front_ready;

endmodule

`default_nettype wire
